FILE: rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg: shared types, constants and functions of the tilt filter
// Payload structs, controller states, datapath commands, the arctangent
// table of the CORDIC and the 24-bit angle saturation.
// ----------------------------------------------------------------------------
package tcf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_LEN         = 24;
	localparam int CORDIC_IDX_W     = 5;

	localparam int ANGLE_W = 24;
	localparam int XY_W    = 20;
	localparam int Z_W     = 26;
	localparam int ACC_W   = Z_W - 8;
	localparam int SUM_W   = 26;
	localparam int INC_W   = 25;
	localparam int OP_B_W  = 18;
	localparam int PROD_W  = SUM_W + OP_B_W;
	localparam int SAT_W   = 28;

	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_GAIN = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE_SCALE = 8'd1;
	localparam logic [15:0] BLEND_GAIN_RESET = 16'd64225;
	localparam logic [15:0] RATE_SCALE_RESET = 16'd256;

	localparam logic signed [Z_W-1:0] HALF_TURN_Q16 = 26'sd11796480;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -24'sh800000;

	typedef struct packed {
		logic signed [15:0] accel_forward;
		logic signed [15:0] accel_vertical;
		logic signed [15:0] gyro_rate;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] filtered_angle;
		logic signed [ANGLE_W-1:0] accel_angle;
		logic signed [ANGLE_W-1:0] gyro_tilt;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RATE,
		S_INC,
		S_CORDIC,
		S_MIX1,
		S_MIX2,
		S_MIX3,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_RATE,
		MUL_GAIN,
		MUL_COMP
	} mul_sel_t;

	typedef struct packed {
		logic                    load;
		logic                    mul_en;
		mul_sel_t                mul_sel;
		logic                    inc_en;
		logic                    cordic_en;
		logic [CORDIC_IDX_W-1:0] idx;
		logic                    acc_load;
		logic                    acc_add;
		logic                    commit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	// Arctangent of 2^-i in 1/65536 degree, rounded to nearest.
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [CORDIC_IDX_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			5'd0:    v = 26'sd2949120;
			5'd1:    v = 26'sd1740967;
			5'd2:    v = 26'sd919879;
			5'd3:    v = 26'sd466945;
			5'd4:    v = 26'sd234379;
			5'd5:    v = 26'sd117304;
			5'd6:    v = 26'sd58666;
			5'd7:    v = 26'sd29335;
			5'd8:    v = 26'sd14668;
			5'd9:    v = 26'sd7334;
			5'd10:   v = 26'sd3667;
			5'd11:   v = 26'sd1833;
			5'd12:   v = 26'sd917;
			5'd13:   v = 26'sd458;
			5'd14:   v = 26'sd229;
			5'd15:   v = 26'sd115;
			5'd16:   v = 26'sd57;
			5'd17:   v = 26'sd29;
			5'd18:   v = 26'sd14;
			5'd19:   v = 26'sd7;
			5'd20:   v = 26'sd4;
			5'd21:   v = 26'sd2;
			5'd22:   v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [SAT_W-1:0] v);
		logic signed [ANGLE_W-1:0] r;
		if (v > SAT_W'(ANGLE_MAX)) begin
			r = ANGLE_MAX;
		end else if (v < SAT_W'(ANGLE_MIN)) begin
			r = ANGLE_MIN;
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/tcf_ctrl.sv
// ----------------------------------------------------------------------------
// tcf_ctrl: sequencer of the tilt filter
// Steps one sample through gyro scaling, the CORDIC iterations, the two
// blend products and the final commit into the result register.
// ----------------------------------------------------------------------------
module tcf_ctrl #(
	parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  tcf_pkg::status_t status,
	output tcf_pkg::cmd_t    cmd
);
	import tcf_pkg::*;

	localparam int IDX_W = $clog2(CORDIC_STEPS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CORDIC_STEPS - 1);

	state_t state_q;
	state_t state_d;
	logic [IDX_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.cordic_en) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		sample_ready  = 1'b0;
		cmd           = '0;
		cmd.mul_sel   = MUL_RATE;
		cmd.idx       = CORDIC_IDX_W'(idx_q);
		case (state_q)
			S_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RATE;
				end
			end
			S_RATE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RATE;
				state_d     = S_INC;
			end
			S_INC: begin
				cmd.inc_en = 1'b1;
				state_d    = S_CORDIC;
			end
			S_CORDIC: begin
				cmd.cordic_en = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_d = S_MIX1;
				end
			end
			S_MIX1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GAIN;
				state_d     = S_MIX2;
			end
			S_MIX2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_COMP;
				cmd.acc_load = 1'b1;
				state_d      = S_MIX3;
			end
			S_MIX3: begin
				cmd.acc_add = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				// Hold the finished sample until the result register frees up.
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_idx_only_in_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> state_q == S_CORDIC)
		else $error("CORDIC index moved outside the iteration state");

	a_accept_starts_rate: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> state_q == S_RATE && idx_q == '0)
		else $error("accepted beat did not start a fresh sequence");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !cmd.commit |=> state_q == S_DONE)
		else $error("finished sample dropped while result register was busy");

endmodule

FILE: rtl/tcf_datapath.sv
// ----------------------------------------------------------------------------
// tcf_datapath: arithmetic of the tilt filter
// Vectoring CORDIC registers, one shared signed multiplier with its
// product and blend accumulators, filter state and the result register.
// ----------------------------------------------------------------------------
module tcf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  tcf_pkg::cmd_t    cmd,
	output tcf_pkg::status_t status,
	input  tcf_pkg::sample_t sample,
	input  logic [15:0]      blend_gain,
	input  logic [15:0]      rate_scale,
	output logic             result_valid,
	input  logic             result_ready,
	output tcf_pkg::result_t result
);
	import tcf_pkg::*;

	logic signed [XY_W-1:0]    x_q;
	logic signed [XY_W-1:0]    y_q;
	logic signed [Z_W-1:0]     z_q;
	logic                      zero_q;
	logic signed [15:0]        rate_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  mix_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [ANGLE_W-1:0] gyro_q;
	logic signed [ANGLE_W-1:0] last_filtered_q;
	logic signed [ANGLE_W-1:0] gyro_integral_q;
	logic                      result_valid_q;
	result_t                   result_q;

	logic signed [XY_W-1:0]    fwd_ext;
	logic signed [XY_W-1:0]    vert_ext;
	logic                      vert_neg;
	logic signed [XY_W-1:0]    dx;
	logic signed [XY_W-1:0]    dy;
	logic signed [Z_W-1:0]     atan_val;
	logic signed [Z_W-1:0]     z_round;
	logic signed [ACC_W-1:0]   acc_val;
	logic signed [OP_B_W-1:0]  comp_gain;
	logic signed [SUM_W-1:0]   op_a;
	logic signed [OP_B_W-1:0]  op_b;
	logic signed [PROD_W-1:0]  prod_full;
	logic signed [PROD_W-1:0]  prod_round;
	logic signed [INC_W-1:0]   inc;
	logic signed [SUM_W-1:0]   gyro_sum;
	logic signed [SUM_W-1:0]   path_sum;
	logic signed [PROD_W-1:0]  mix_round;
	logic signed [ANGLE_W-1:0] filt;

	assign fwd_ext  = {{(XY_W-16){sample.accel_forward[15]}}, sample.accel_forward};
	assign vert_ext = {{(XY_W-16){sample.accel_vertical[15]}}, sample.accel_vertical};
	assign vert_neg = sample.accel_vertical[15];

	assign dx       = y_q >>> cmd.idx;
	assign dy       = x_q >>> cmd.idx;
	assign atan_val = atan_entry(cmd.idx);

	// Accelerometer angle: accumulator rounded from 1/65536 to 1/256 degree.
	assign z_round = z_q + Z_W'(128);
	assign acc_val = zero_q ? '0 : z_round[Z_W-1:8];

	assign comp_gain = OP_B_W'(18'sd65536 - $signed({2'b00, blend_gain}));

	always_comb begin
		case (cmd.mul_sel)
			MUL_RATE: begin
				op_a = {{(SUM_W-16){rate_q[15]}}, rate_q};
				op_b = {2'b00, rate_scale};
			end
			MUL_GAIN: begin
				op_a = sum_q;
				op_b = {2'b00, blend_gain};
			end
			MUL_COMP: begin
				op_a = {{(SUM_W-ACC_W){acc_val[ACC_W-1]}}, acc_val};
				op_b = comp_gain;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_full = op_a * op_b;

	// Gyro increment: rate times Q8.8 scale, rounded, fits in 25 bits.
	assign prod_round = prod_q + PROD_W'(128);
	assign inc        = prod_round[INC_W+7:8];
	assign gyro_sum   = SUM_W'(gyro_integral_q) + SUM_W'(inc);
	assign path_sum   = SUM_W'(last_filtered_q) + SUM_W'(inc);

	assign mix_round = mix_q + PROD_W'(32768);
	assign filt      = sat_angle(mix_round[SAT_W+15:16]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= vert_neg ? -vert_ext : vert_ext;
			y_q    <= vert_neg ? -fwd_ext : fwd_ext;
			if (vert_neg) begin
				z_q <= sample.accel_forward[15] ? -HALF_TURN_Q16 : HALF_TURN_Q16;
			end else begin
				z_q <= '0;
			end
			zero_q <= (sample.accel_forward == '0) && (sample.accel_vertical == '0);
			rate_q <= sample.gyro_rate;
		end else if (cmd.cordic_en) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_val;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_val;
			end
		end
		if (cmd.mul_en) begin
			prod_q <= prod_full;
		end
		if (cmd.inc_en) begin
			gyro_q <= sat_angle(SAT_W'(gyro_sum));
			sum_q  <= path_sum;
		end
		if (cmd.acc_load) begin
			mix_q <= prod_q;
		end else if (cmd.acc_add) begin
			mix_q <= mix_q + prod_q;
		end
		if (cmd.commit) begin
			result_q.filtered_angle <= filt;
			result_q.accel_angle    <= ANGLE_W'(acc_val);
			result_q.gyro_tilt      <= gyro_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_filtered_q <= '0;
			gyro_integral_q <= '0;
			result_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				last_filtered_q <= filt;
				gyro_integral_q <= gyro_q;
				result_valid_q  <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = result_valid_q && !result_ready;
	assign result_valid    = result_valid_q;
	assign result          = result_q;

	a_commit_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !status.out_busy)
		else $error("result overwritten while the receiver stalls");

	// The half-turn start plus the sum of all rotations bounds the angle,
	// whatever the iteration count.
	a_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (acc_val <= 18'sd71680) && (acc_val >= -18'sd71680))
		else $error("accelerometer angle outside the CORDIC reach");

	a_state_matches_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result_valid_q && last_filtered_q == result_q.filtered_angle
			&& gyro_integral_q == result_q.gyro_tilt)
		else $error("filter state and delivered beat disagree");

endmodule

FILE: rtl/tilt_complementary_filter_core.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter_core: complementary-filter tilt estimator
// One IMU sample in, one set of tilt angles out, in 1/256 degree units.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel takes one beat of accelerometer forward and vertical
//   axes plus the gyro rate. The result channel returns one beat per sample
//   with the filtered, accelerometer-only and gyro-only angles.
//   The cfg channel writes blend_gain (index 0) and rate_scale (index 1);
//   other indexes are ignored. It is always ready and should be used only
//   while no sample is in flight.
// Timing:
//   A result turns valid once its sample has passed the rate, increment,
//   CORDIC_STEPS CORDIC rotations and mix steps; the next sample can be
//   taken in the same cycle as the result turns valid. The block works on
//   one sample at a time: a serial CORDIC, one rotation per cycle, and a
//   single multiplier shared by the gyro scaling and both blend products.
// Reset and stalls:
//   Reset clears the filter and gyro integrals and loads the default gains.
//   The result register holds its beat while result_ready is low; a new
//   sample is still taken and worked on, and it waits in the final step
//   until the previous beat has been taken.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_core #(
	parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  tcf_pkg::sample_t                sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output tcf_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                     cfg_data
);
	import tcf_pkg::*;

	logic [15:0] blend_gain_q;
	logic [15:0] rate_scale_q;
	cmd_t        cmd;
	status_t     status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_gain_q <= BLEND_GAIN_RESET;
			rate_scale_q <= RATE_SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BLEND_GAIN: blend_gain_q <= cfg_data;
				CFG_RATE_SCALE: rate_scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tcf_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (status),
		.cmd          (cmd)
	);

	tcf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.blend_gain   (blend_gain_q),
		.rate_scale   (rate_scale_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
